// ===== rtl/zla_pkg.sv =====
// zla_pkg: shared types and codes for the zone leak alarm latch.
// Holds request/result structs, the per-zone state record and register indexes.
// No dependencies.
`default_nettype none

package zla_pkg;

  localparam int NUM_ZONES_DEF = 8;

  localparam logic [1:0] FUNC_SCAN    = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_ACK_ALL = 2'd2;
  localparam logic [1:0] FUNC_RSVD    = 2'd3;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_DETECT = 2'd1;
  localparam logic [1:0] EV_ACK    = 2'd2;

  localparam logic [2:0] CFG_CTRL_EN  = 3'd0;
  localparam logic [2:0] CFG_ZONE_EN  = 3'd1;
  localparam logic [2:0] CFG_ZONE_PWR = 3'd2;
  localparam logic [2:0] CFG_ACT_LOW  = 3'd3;
  localparam logic [2:0] CFG_PRESENT  = 3'd4;
  localparam logic [2:0] CFG_DEBOUNCE = 3'd5;

  localparam logic [15:0] DEBOUNCE_RST = 16'd1000;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  zone;
    logic        sensor_raw;
    logic        read_ok;
    logic [31:0] now_ms;
  } zla_in_t;

  typedef struct packed {
    logic [2:0] zone_out;
    logic       wet_now;
    logic       latched;
    logic       alarm_drive;
    logic       valve_shut;
    logic [1:0] event_code;
    logic       handled;
    logic       last;
  } zla_out_t;

  // one zone's stored state
  typedef struct packed {
    logic        wet;
    logic        prev_wet;
    logic        latch;
    logic        alarm;
    logic [31:0] event_time;
  } zone_rec_t;

  // settings that apply to the zone being updated
  typedef struct packed {
    logic        ctrl_en;
    logic        enabled;
    logic        powered;
    logic        inv_pol;
    logic        present;
    logic [15:0] debounce;
  } zone_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/zla_state_mem.sv =====
// zla_state_mem: per-zone state memory, one write and one read port, registered read.
// Entries never written read as zero through per-entry valid bits. Uses zla_pkg.
`default_nettype none

module zla_state_mem
  import zla_pkg::*;
#(
  parameter int NUM_ZONES = NUM_ZONES_DEF,
  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      rd_en,
  input  wire logic [ZW-1:0] rd_addr,
  output zone_rec_t      rd_data,
  input  wire logic      wr_en,
  input  wire logic [ZW-1:0] wr_addr,
  input  wire zone_rec_t wr_data
);

  zone_rec_t mem [NUM_ZONES];
  logic [NUM_ZONES-1:0] vld;
  zone_rec_t q;
  logic q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        q_vld <= vld[rd_addr];
      end
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule

`default_nettype wire

// ===== rtl/zla_update.sv =====
// zla_update: next state of one zone for a scan or an acknowledge.
// Combinational; works on a record read from zla_state_mem. Uses zla_pkg.
`default_nettype none

module zla_update
  import zla_pkg::*;
(
  input  wire zone_rec_t   rec_in,
  input  wire zone_cfg_t   cfg,
  input  wire logic        is_ack,
  input  wire logic        sensor_raw,
  input  wire logic        read_ok,
  input  wire logic [31:0] now_ms,
  output zone_rec_t        rec_out,
  output logic [1:0]       event_code,
  output logic             handled
);

  logic        wet;
  logic [31:0] elapsed;

  assign wet     = sensor_raw ^ cfg.inv_pol;
  assign elapsed = now_ms - rec_in.event_time;

  always_comb begin
    rec_out    = rec_in;
    event_code = EV_NONE;
    handled    = 1'b0;
    if (is_ack) begin
      if (!rec_in.wet && rec_in.latch) begin
        rec_out.latch = 1'b0;
        rec_out.alarm = 1'b0;
        event_code    = EV_ACK;
        handled       = 1'b1;
      end
    end else if (!cfg.ctrl_en || !cfg.enabled) begin
      rec_out = '0;
    end else begin
      handled = 1'b1;
      if (!cfg.powered) begin
        rec_out.wet      = 1'b0;
        rec_out.prev_wet = 1'b0;
        rec_out.latch    = 1'b0;
        rec_out.alarm    = 1'b0;
      end else if (!cfg.present || !read_ok) begin
        rec_out.alarm = 1'b1;
      end else begin
        rec_out.wet = wet;
        if (wet && !rec_in.prev_wet) begin
          // stored time of zero means no event yet
          if ((rec_in.event_time == 32'd0) || (elapsed >= {16'd0, cfg.debounce})) begin
            event_code         = EV_DETECT;
            rec_out.event_time = now_ms;
          end
        end
        rec_out.latch    = rec_in.latch | wet;
        rec_out.alarm    = rec_in.latch | wet;
        rec_out.prev_wet = wet;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/zone_leak_alarm_latch.sv =====
// zone_leak_alarm_latch: top level of the multi-zone leak alarm.
// Holds config registers and the request sequencer; uses zla_pkg, zla_state_mem, zla_update.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | in_data  (zla_in_t)
//   out     | out_valid / out_stall| out_data (zla_out_t)
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Scan and single ack go through a memory read, then update and write back.
// Ack-all visits every zone, one per cycle through the memory port unless the output stalls.
// Reset clears all zone state at once through per-entry valid bits.
// A stalled result register holds the sequencer in its update step.
`default_nettype none

module zone_leak_alarm_latch
  import zla_pkg::*;
#(
  parameter int NUM_ZONES = NUM_ZONES_DEF,
  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire zla_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output zla_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic {ST_IDLE, ST_MOD} state_t;

  state_t      state;
  zla_in_t     req;
  logic        req_all;
  logic        oor;
  logic [ZW-1:0] addr;

  logic        ctrl_en;
  logic [7:0]  zone_en;
  logic [7:0]  zone_pwr;
  logic [7:0]  act_low;
  logic [7:0]  present;
  logic [15:0] debounce;

  logic        in_acc;
  logic        in_oor;
  logic        emit;
  logic        is_last;
  logic        rd_en;
  logic [ZW-1:0] rd_addr;
  logic        wr_en;
  zone_rec_t   rd_rec;
  zone_rec_t   new_rec;
  zone_cfg_t   zcfg;
  logic [1:0]  ev;
  logic        hd;
  zla_out_t    res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_oor    = (32'(in_data.zone) >= NUM_ZONES);
  assign emit      = (state == ST_MOD) && (!out_valid || !out_stall);
  assign is_last   = !req_all || (addr == ZW'(NUM_ZONES - 1));
  assign wr_en     = emit && !oor;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr + ZW'(1);
    if (state == ST_IDLE) begin
      rd_addr = (in_data.func == FUNC_ACK_ALL) ? '0 : ZW'(in_data.zone);
      if (in_acc) begin
        case (in_data.func)
          FUNC_ACK_ALL:        rd_en = 1'b1;
          FUNC_SCAN, FUNC_ACK: rd_en = !in_oor;
          default:             rd_en = 1'b0;
        endcase
      end
    end else begin
      rd_en = emit && !is_last;
    end
  end

  assign zcfg.ctrl_en  = ctrl_en;
  assign zcfg.enabled  = zone_en[req.zone];
  assign zcfg.powered  = zone_pwr[req.zone];
  assign zcfg.inv_pol  = act_low[req.zone];
  assign zcfg.present  = present[req.zone];
  assign zcfg.debounce = debounce;

  zla_state_mem #(.NUM_ZONES(NUM_ZONES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (new_rec)
  );

  zla_update u_upd (
    .rec_in     (rd_rec),
    .cfg        (zcfg),
    .is_ack     (req.func != FUNC_SCAN),
    .sensor_raw (req.sensor_raw),
    .read_ok    (req.read_ok),
    .now_ms     (req.now_ms),
    .rec_out    (new_rec),
    .event_code (ev),
    .handled    (hd)
  );

  always_comb begin
    if (oor) begin
      res          = '0;
      res.zone_out = req.zone;
      res.last     = 1'b1;
    end else begin
      res.zone_out    = req_all ? 3'(addr) : req.zone;
      res.wet_now     = new_rec.wet;
      res.latched     = new_rec.latch;
      res.alarm_drive = new_rec.alarm;
      res.valve_shut  = new_rec.alarm;
      res.event_code  = ev;
      res.handled     = hd;
      res.last        = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_en  <= 1'b1;
      zone_en  <= '0;
      zone_pwr <= '0;
      act_low  <= '0;
      present  <= '0;
      debounce <= DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CTRL_EN:  ctrl_en  <= cfg_data[0];
        CFG_ZONE_EN:  zone_en  <= cfg_data[7:0];
        CFG_ZONE_PWR: zone_pwr <= cfg_data[7:0];
        CFG_ACT_LOW:  act_low  <= cfg_data[7:0];
        CFG_PRESENT:  present  <= cfg_data[7:0];
        CFG_DEBOUNCE: debounce <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      req_all   <= 1'b0;
      oor       <= 1'b0;
      addr      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && (in_data.func != FUNC_RSVD)) begin
            state   <= ST_MOD;
            req_all <= (in_data.func == FUNC_ACK_ALL);
            oor     <= (in_data.func != FUNC_ACK_ALL) && in_oor;
            addr    <= rd_addr;
          end
        end
        ST_MOD: begin
          if (emit) begin
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              addr <= addr + ZW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req <= in_data;
    end
    if (emit) begin
      out_data <= res;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> rd_addr != addr)
    else $error("read and write of the same zone in one cycle");

  a_read_then_mod: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> state == ST_MOD)
    else $error("memory read issued without an update step following");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    emit && !req_all |=> state == ST_IDLE)
    else $error("single request did not finish after one result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_MOD && !emit |=> state == ST_MOD && $stable(addr))
    else $error("update step moved while result register was blocked");

  a_write_in_mod: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == ST_MOD && !oor)
    else $error("state write outside the update step");

endmodule

`default_nettype wire
